>>> hw/rtl/pci_pkg.sv
// Shared types and constants for the particle collision impulse block.
// Holds the transaction payload structs, command codes and controller/datapath interface.
package pci_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] TYPE_FLUID = 2'd0;
    localparam logic [1:0] TYPE_GHOST = 2'd2;

    localparam logic [20:0] COUNT_CAP = 21'd1048576;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [1:0]         ptype;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic [1:0]         out_type;
        logic [20:0]        impulse_count;
    } result_t;

    typedef logic [2:0][31:0] vec3_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ_ITEM,
        OP_RUN_START,
        OP_LOAD,
        OP_LATCH_I,
        OP_DIFF,
        OP_SQUARE,
        OP_SUM,
        OP_SQRT_START,
        OP_DIV_START,
        OP_DOT_MUL,
        OP_DOT_SUM,
        OP_GAIN_MUL,
        OP_IMP_MUL,
        OP_APPLY,
        OP_STORE_I,
        OP_UPD_MUL,
        OP_UPD_WRITE,
        OP_OUT_READ,
        OP_OUT_RUN
    } op_t;

    typedef struct packed {
        logic [1:0] rd_type;
        logic       far;
        logic       close;
        logic       a_pos;
        logic       sqrt_done;
        logic       div_done;
    } sts_t;

endpackage

>>> hw/rtl/pci_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing outside this file.
module pci_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [61:0] value,
    output logic        busy,
    output logic [30:0] root
);

    logic [61:0] val_reg;
    logic [33:0] rem_reg;
    logic [30:0] root_reg;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic [35:0] rem2;
    logic [35:0] trial;

    assign rem2  = {rem_reg, val_reg[61:60]};
    assign trial = {3'b000, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == 5'd0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= 5'd30;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[59:0], 2'b00};
            step_reg <= step_reg - 5'd1;
            if (rem2 >= trial) begin
                rem_reg  <= 34'(rem2 - trial);
                root_reg <= {root_reg[29:0], 1'b1};
            end else begin
                rem_reg  <= rem2[33:0];
                root_reg <= {root_reg[29:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> hw/rtl/pci_div.sv
// Restoring divider for one unit-vector lane: (num * 65536) / den, truncated toward zero.
// Depends on nothing outside this file; the quotient magnitude never exceeds 65536 while |num| <= den.
module pci_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic [30:0]        den,
    output logic               busy,
    output logic signed [17:0] quot
);

    logic [30:0] r_reg;
    logic        nbit_reg;
    logic [16:0] q_reg;
    logic        neg_reg;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic [31:0] mag;
    logic [31:0] r2;
    logic [17:0] q_ext;

    assign mag   = num[31] ? 32'(-num) : 32'(num);
    assign r2    = {r_reg, nbit_reg};
    assign q_ext = {1'b0, q_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && step_reg == 5'd0) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= num[31];
            r_reg    <= {1'b0, mag[30:1]};
            nbit_reg <= mag[0];
            q_reg    <= '0;
            step_reg <= 5'd16;
        end else if (busy_reg) begin
            nbit_reg <= 1'b0;
            step_reg <= step_reg - 5'd1;
            if (r2 >= {1'b0, den}) begin
                r_reg <= 31'(r2 - {1'b0, den});
                q_reg <= {q_reg[15:0], 1'b1};
            end else begin
                r_reg <= r2[30:0];
                q_reg <= {q_reg[15:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? $signed(-q_ext) : $signed(q_ext);

endmodule

>>> hw/rtl/pci_datapath.sv
// Datapath: particle memories, pair arithmetic and position update.
// Depends on pci_pkg, pci_sqrt and pci_div; steered op by op by pci_ctrl.
module pci_datapath import pci_pkg::*; #(
    parameter int MAX_PARTICLES = 1024,
    localparam int IDX_W = $clog2(MAX_PARTICLES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  op_t              op,
    input  logic [IDX_W-1:0] addr,
    input  item_t            in_item,
    input  logic [61:0]      cds,
    input  logic [16:0]      restitution,
    input  logic [30:0]      time_step,
    output sts_t             sts,
    output result_t          result
);

    vec3_t      pos_mem  [MAX_PARTICLES];
    vec3_t      vel_mem  [MAX_PARTICLES];
    vec3_t      nvel_mem [MAX_PARTICLES];
    logic [1:0] type_mem [MAX_PARTICLES];

    vec3_t      pos_rd_reg;
    vec3_t      vel_rd_reg;
    vec3_t      nvel_rd_reg;
    logic [1:0] type_rd_reg;
    vec3_t      pos_i_reg;
    vec3_t      vi_reg;
    logic       in_range_reg;

    logic signed [32:0] d_reg    [3];
    logic [62:0]        sq_reg   [3];
    logic [63:0]        dist2_reg;
    logic signed [50:0] prod_reg [3];
    logic signed [52:0] a_reg;
    logic [54:0]        gm_reg;
    logic signed [56:0] imp_reg  [3];
    logic signed [64:0] upd_reg  [3];
    logic [20:0]        count_reg;

    logic signed [32:0] d_next   [3];
    logic               far_k    [3];
    logic signed [63:0] sq_full  [3];
    logic signed [32:0] dv       [3];
    logic signed [50:0] prod_next[3];
    logic signed [56:0] imp_next [3];
    logic signed [56:0] imp_adj  [3];
    logic [31:0]        vi_new   [3];
    logic signed [32:0] dvn      [3];
    logic signed [64:0] upd_next [3];
    logic signed [64:0] upd_adj  [3];
    logic [31:0]        pos_new  [3];
    logic signed [17:0] u        [3];
    logic               div_busy [3];

    logic [63:0]        dist2_next;
    logic signed [52:0] a_next;
    logic [17:0]        e_fac;
    logic [54:0]        gm_next;
    logic signed [38:0] g_s;
    logic signed [31:0] ts_s;
    logic [30:0]        dist_root;
    logic               sqrt_busy;

    logic [IDX_W-1:0] item_addr;
    logic             item_ok;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic             rd_en;
    logic             pv_we;
    logic             type_we;
    vec3_t            pos_wdata;
    vec3_t            vel_wdata;
    vec3_t            pos_new_v;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'h7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'h80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    assign item_addr = IDX_W'(in_item.index);
    assign item_ok   = 32'(in_item.index) < 32'(MAX_PARTICLES);
    assign rd_en     = (op == OP_LOAD) || (op == OP_READ_ITEM);
    assign raddr     = (op == OP_READ_ITEM) ? item_addr : addr;
    assign waddr     = (op == OP_WRITE) ? item_addr : addr;
    assign pv_we     = ((op == OP_WRITE) && item_ok) || (op == OP_UPD_WRITE);
    assign type_we   = (op == OP_WRITE) && item_ok;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_next[k]    = 33'($signed(pos_rd_reg[k])) - 33'($signed(pos_i_reg[k]));
            far_k[k]     = (d_reg[k] > 33'sd2147483647) || (d_reg[k] < -33'sd2147483647);
            sq_full[k]   = 64'($signed(d_reg[k][31:0])) * 64'($signed(d_reg[k][31:0]));
            dv[k]        = 33'($signed(vi_reg[k])) - 33'($signed(vel_rd_reg[k]));
            prod_next[k] = 51'(dv[k]) * 51'(u[k]);
            imp_next[k]  = 57'(g_s) * 57'(u[k]);
            imp_adj[k]   = imp_reg[k] + (imp_reg[k][56] ? 57'sd65535 : 57'sd0);
            vi_new[k]    = sat32(66'($signed(vi_reg[k])) - 66'($signed(imp_adj[k][56:16])));
            dvn[k]       = 33'($signed(nvel_rd_reg[k])) - 33'($signed(vel_rd_reg[k]));
            upd_next[k]  = 65'(dvn[k]) * 65'(ts_s);
            upd_adj[k]   = upd_reg[k] + (upd_reg[k][64] ? 65'sd65535 : 65'sd0);
            pos_new[k]   = sat32(66'($signed(pos_rd_reg[k])) + 66'($signed(upd_adj[k][64:16])));
            pos_new_v[k] = pos_new[k];
        end
    end

    assign dist2_next = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
    assign a_next     = 53'(prod_reg[0]) + 53'(prod_reg[1]) + 53'(prod_reg[2]);
    assign e_fac      = 18'(restitution) + 18'd65536;
    assign gm_next    = 55'(a_reg[52:16]) * 55'(e_fac);
    assign g_s        = $signed({1'b0, gm_reg[54:17]});
    assign ts_s       = $signed({1'b0, time_step});

    assign pos_wdata = (op == OP_WRITE) ? vec3_t'({in_item.pos_z, in_item.pos_y, in_item.pos_x})
                                        : pos_new_v;
    assign vel_wdata = (op == OP_WRITE) ? vec3_t'({in_item.vel_z, in_item.vel_y, in_item.vel_x})
                                        : nvel_rd_reg;

    always_ff @(posedge aclk) begin
        if (pv_we) begin
            pos_mem[waddr] <= pos_wdata;
        end
        if (rd_en) begin
            pos_rd_reg <= pos_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pv_we) begin
            vel_mem[waddr] <= vel_wdata;
        end
        if (rd_en) begin
            vel_rd_reg <= vel_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_STORE_I) begin
            nvel_mem[addr] <= vi_reg;
        end
        if (rd_en) begin
            nvel_rd_reg <= nvel_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (type_we) begin
            type_mem[item_addr] <= in_item.ptype;
        end
        if (rd_en) begin
            type_rd_reg <= type_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_RUN_START) begin
            count_reg <= '0;
        end else if (op == OP_APPLY && count_reg != COUNT_CAP) begin
            count_reg <= count_reg + 21'd1;
        end
        if (op == OP_READ_ITEM) begin
            in_range_reg <= item_ok;
        end
        if (op == OP_LATCH_I) begin
            pos_i_reg <= pos_rd_reg;
            vi_reg    <= vel_rd_reg;
        end
        if (op == OP_SUM) begin
            dist2_reg <= dist2_next;
        end
        if (op == OP_DOT_SUM) begin
            a_reg <= a_next;
        end
        if (op == OP_GAIN_MUL) begin
            gm_reg <= gm_next;
        end
        for (int k = 0; k < 3; k++) begin
            if (op == OP_DIFF) begin
                d_reg[k] <= d_next[k];
            end
            if (op == OP_SQUARE) begin
                sq_reg[k] <= sq_full[k][62:0];
            end
            if (op == OP_DOT_MUL) begin
                prod_reg[k] <= prod_next[k];
            end
            if (op == OP_IMP_MUL) begin
                imp_reg[k] <= imp_next[k];
            end
            if (op == OP_APPLY) begin
                vi_reg[k] <= vi_new[k];
            end
            if (op == OP_UPD_MUL) begin
                upd_reg[k] <= upd_next[k];
            end
        end
    end

    pci_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (op == OP_SQRT_START),
        .value   (dist2_reg[61:0]),
        .busy    (sqrt_busy),
        .root    (dist_root)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        pci_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (op == OP_DIV_START),
            .num     ($signed(d_reg[k][31:0])),
            .den     (dist_root),
            .busy    (div_busy[k]),
            .quot    (u[k])
        );
    end

    always_comb begin
        sts.rd_type   = type_rd_reg;
        sts.far       = far_k[0] || far_k[1] || far_k[2];
        sts.close     = (dist2_reg < {2'b00, cds}) && (dist2_reg != '0);
        sts.a_pos     = !a_reg[52] && (a_reg != '0);
        sts.sqrt_done = !sqrt_busy;
        sts.div_done  = !(div_busy[0] || div_busy[1] || div_busy[2]);
    end

    always_comb begin
        result = '0;
        if (op == OP_OUT_RUN) begin
            result.impulse_count = count_reg;
        end else if (in_range_reg) begin
            result.out_pos_x = pos_rd_reg[0];
            result.out_pos_y = pos_rd_reg[1];
            result.out_pos_z = pos_rd_reg[2];
            result.out_vel_x = vel_rd_reg[0];
            result.out_vel_y = vel_rd_reg[1];
            result.out_vel_z = vel_rd_reg[2];
            result.out_type  = type_rd_reg;
        end
    end

endmodule

>>> hw/rtl/pci_ctrl.sv
// Controller: sequences transactions, the pair loops of a run and the position update pass.
// Depends on pci_pkg; drives pci_datapath through op and addr, reads back sts.
module pci_ctrl import pci_pkg::*; #(
    parameter int MAX_PARTICLES = 1024,
    localparam int IDX_W = $clog2(MAX_PARTICLES),
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       item_cmd,
    input  logic [CNT_W-1:0] n_cnt,
    input  logic             out_free,
    input  sts_t             sts,
    output op_t              op,
    output logic [IDX_W-1:0] addr
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ_OUT,
        ST_LOAD_I,
        ST_LATCH_I,
        ST_LOAD_J,
        ST_DIFF,
        ST_SQUARE,
        ST_SUM,
        ST_CLOSE,
        ST_SQRT,
        ST_DIV,
        ST_DOT_SUM,
        ST_GAIN,
        ST_IMP_MUL,
        ST_APPLY,
        ST_STORE_I,
        ST_UPD_LOAD,
        ST_UPD_MUL,
        ST_UPD_WRITE,
        ST_RUN_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        op         = OP_NONE;
        addr       = i_reg[IDX_W-1:0];
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (item_cmd)
                        CMD_WRITE: op = OP_WRITE;
                        CMD_RUN: begin
                            op         = OP_RUN_START;
                            i_next     = '0;
                            state_next = ST_LOAD_I;
                        end
                        CMD_READ: begin
                            op         = OP_READ_ITEM;
                            state_next = ST_READ_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ_OUT: begin
                if (out_free) begin
                    op         = OP_OUT_READ;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD_I: begin
                if (i_reg == n_cnt) begin
                    i_next     = '0;
                    state_next = ST_UPD_LOAD;
                end else begin
                    op         = OP_LOAD;
                    state_next = ST_LATCH_I;
                end
            end
            ST_LATCH_I: begin
                if (sts.rd_type != TYPE_FLUID) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_LOAD_I;
                end else begin
                    op         = OP_LATCH_I;
                    j_next     = '0;
                    state_next = ST_LOAD_J;
                end
            end
            ST_LOAD_J: begin
                addr = j_reg[IDX_W-1:0];
                if (j_reg == n_cnt) begin
                    state_next = ST_STORE_I;
                end else if (j_reg == i_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    op         = OP_LOAD;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                if (sts.rd_type == TYPE_GHOST) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_LOAD_J;
                end else begin
                    op         = OP_DIFF;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (sts.far) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_LOAD_J;
                end else begin
                    op         = OP_SQUARE;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                op         = OP_SUM;
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (!sts.close) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_LOAD_J;
                end else begin
                    op         = OP_SQRT_START;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sts.sqrt_done) begin
                    op         = OP_DIV_START;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    op         = OP_DOT_MUL;
                    state_next = ST_DOT_SUM;
                end
            end
            ST_DOT_SUM: begin
                op         = OP_DOT_SUM;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                if (!sts.a_pos) begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_LOAD_J;
                end else begin
                    op         = OP_GAIN_MUL;
                    state_next = ST_IMP_MUL;
                end
            end
            ST_IMP_MUL: begin
                op         = OP_IMP_MUL;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                op         = OP_APPLY;
                j_next     = j_reg + 1'b1;
                state_next = ST_LOAD_J;
            end
            ST_STORE_I: begin
                op         = OP_STORE_I;
                i_next     = i_reg + 1'b1;
                state_next = ST_LOAD_I;
            end
            ST_UPD_LOAD: begin
                if (i_reg == n_cnt) begin
                    state_next = ST_RUN_OUT;
                end else begin
                    op         = OP_LOAD;
                    state_next = ST_UPD_MUL;
                end
            end
            ST_UPD_MUL: begin
                if (sts.rd_type != TYPE_FLUID) begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_UPD_LOAD;
                end else begin
                    op         = OP_UPD_MUL;
                    state_next = ST_UPD_WRITE;
                end
            end
            ST_UPD_WRITE: begin
                op         = OP_UPD_WRITE;
                i_next     = i_reg + 1'b1;
                state_next = ST_UPD_LOAD;
            end
            ST_RUN_OUT: begin
                if (out_free) begin
                    op         = OP_OUT_RUN;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_run_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && item_cmd == CMD_RUN) |=> !s_ready)
        else $error("input accepted during a run");

    a_sqrt_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_SQRT_START) |-> sts.close)
        else $error("square root started on a pair that is not close");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_OUT_RUN || op == OP_OUT_READ) |-> out_free)
        else $error("result loaded over a pending transaction");

    a_apply_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_APPLY) |-> $past(op == OP_IMP_MUL))
        else $error("impulse applied without its product");
`endif

endmodule

>>> hw/rtl/particle_collision_impulse.sv
// Write transactions update the particle memories when accepted; read transactions read the
// memories, then load the result register once it is free. Run: each fluid particle is loaded
// and latched, and each partner is loaded and rejected early or, when close, taken through the
// square root and the divider; a non-fluid particle is skipped; a position update pass then
// updates each fluid particle; one transaction at a time. aresetn (synchronous) clears control,
// configuration and result valid; particle memories are undefined until written.
module particle_collision_impulse import pci_pkg::*; #(
    parameter int MAX_PARTICLES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  item_t       s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output result_t     m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_DIST  = 3'd1;
    localparam logic [2:0] REG_REST  = 3'd2;
    localparam logic [2:0] REG_STEP  = 3'd3;
    localparam logic [2:0] REG_MASS  = 3'd4;

    logic [10:0] pc_reg;
    logic [61:0] cds_reg;
    logic [16:0] rest_reg;
    logic [30:0] ts_reg;
    logic [30:0] mass_reg;
    logic        m_valid_reg, m_valid_next;
    result_t     m_data_reg;

    logic             cfg_we;
    logic [CNT_W-1:0] n_cnt;
    logic             out_free;
    logic             out_load;
    op_t              op;
    logic [IDX_W-1:0] addr;
    sts_t             sts;
    result_t          result;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            cds_reg  <= '0;
            rest_reg <= '0;
            ts_reg   <= '0;
            mass_reg <= 31'd65536;
        end else if (cfg_we) begin
            case (paddr[5:3])
                REG_COUNT: pc_reg   <= pwdata[10:0];
                REG_DIST:  cds_reg  <= pwdata[61:0];
                REG_REST:  rest_reg <= pwdata[16:0];
                REG_STEP:  ts_reg   <= pwdata[30:0];
                REG_MASS:  mass_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_COUNT: prdata = 64'(pc_reg);
            REG_DIST:  prdata = 64'(cds_reg);
            REG_REST:  prdata = 64'(rest_reg);
            REG_STEP:  prdata = 64'(ts_reg);
            REG_MASS:  prdata = 64'(mass_reg);
            default:   prdata = '0;
        endcase
    end

    assign n_cnt = (32'(pc_reg) > 32'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES) : CNT_W'(pc_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (op == OP_OUT_RUN) || (op == OP_OUT_READ);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    pci_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .item_cmd (s_data.cmd),
        .n_cnt    (n_cnt),
        .out_free (out_free),
        .sts      (sts),
        .op       (op),
        .addr     (addr)
    );

    pci_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .addr        (addr),
        .in_item     (s_data),
        .cds         (cds_reg),
        .restitution (rest_reg),
        .time_step   (ts_reg),
        .sts         (sts),
        .result      (result)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for particle_collision_impulse: queue-fed driver, monitor, APB setup.
// Predicts write/run/read transactions in place and compares every result field by field.
// Depends on pci_pkg and the particle_collision_impulse RTL only.
`timescale 1ns / 1ps

module tb_top;
    import pci_pkg::*;

    localparam int NPART = 1024;
    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_DIST  = 3'd1;
    localparam logic [2:0] REG_REST  = 3'd2;
    localparam logic [2:0] REG_STEP  = 3'd3;
    localparam logic [2:0] REG_MASS  = 3'd4;
    localparam logic [1:0] TYPE_WALL = 2'd1;
    localparam logic [1:0] TYPE_ODD  = 2'd3;
    localparam logic [1:0] CMD_NOP   = 2'd3;
    localparam logic [61:0] DIST_MAX  = 62'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [61:0] DIST_NEAR = 62'd9663676416;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    item_t       s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    result_t     m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    particle_collision_impulse u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic signed [31:0] pos_mem [NPART][3];
    logic signed [31:0] vel_mem [NPART][3];
    logic [1:0]         typ_mem [NPART];
    logic [10:0]        cfg_count;
    logic [61:0]        cfg_dist;
    logic [16:0]        cfg_rest;
    logic [30:0]        cfg_step;

    item_t   pending_items[$];
    result_t expected_results[$];
    int      stored_idx[$];
    int      errors = 0;
    int      send_idle = 0;
    int      recv_idle = 0;
    bit      hold_req = 0;
    bit      hold_done = 0;
    int      hold_left = 0;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [20:0] collide_all();
        logic signed [31:0] nv [NPART][3];
        longint vi[3], d[3], u[3];
        longint a, g, sd, dv;
        longint unsigned dist2, root;
        int n, cnt;
        bit far;
        n = (cfg_count > NPART) ? NPART : cfg_count;
        cnt = 0;
        nv = vel_mem;
        for (int i = 0; i < n; i++) begin
            if (typ_mem[i] != TYPE_FLUID) continue;
            for (int k = 0; k < 3; k++) vi[k] = vel_mem[i][k];
            for (int j = 0; j < n; j++) begin
                if (j == i || typ_mem[j] == TYPE_GHOST) continue;
                far = 0;
                dist2 = 0;
                a = 0;
                for (int k = 0; k < 3; k++) begin
                    d[k] = longint'(pos_mem[j][k]) - longint'(pos_mem[i][k]);
                    if (d[k] >= 64'sd2147483648 || d[k] <= -64'sd2147483648) far = 1;
                end
                if (far) continue;
                for (int k = 0; k < 3; k++) dist2 = dist2 + longint'(unsigned'(d[k] * d[k]));
                if (!(dist2 < {2'b00, cfg_dist})) continue;
                root = isqrt(dist2);
                if (root == 0) continue;
                sd = root;
                for (int k = 0; k < 3; k++) begin
                    u[k] = (d[k] * 65536) / sd;
                    a = a + (vi[k] - longint'(vel_mem[j][k])) * u[k];
                end
                if (a <= 0) continue;
                g = ((a / 65536) * (65536 + longint'(cfg_rest))) / 131072;
                for (int k = 0; k < 3; k++) vi[k] = sat32(vi[k] - (g * u[k]) / 65536);
                if (cnt < COUNT_CAP) cnt++;
            end
            for (int k = 0; k < 3; k++) nv[i][k] = 32'(vi[k]);
        end
        for (int i = 0; i < n; i++) begin
            if (typ_mem[i] != TYPE_FLUID) continue;
            for (int k = 0; k < 3; k++) begin
                dv = longint'(nv[i][k]) - longint'(vel_mem[i][k]);
                pos_mem[i][k] = sat32(longint'(pos_mem[i][k]) +
                                      (dv * longint'(cfg_step)) / 65536);
                vel_mem[i][k] = nv[i][k];
            end
        end
        return 21'(cnt);
    endfunction

    function automatic void predict_item(item_t it);
        result_t r;
        r = '0;
        case (it.cmd)
            CMD_WRITE: begin
                pos_mem[it.index] = '{it.pos_x, it.pos_y, it.pos_z};
                vel_mem[it.index] = '{it.vel_x, it.vel_y, it.vel_z};
                typ_mem[it.index] = it.ptype;
            end
            CMD_RUN: begin
                r.impulse_count = collide_all();
                expected_results.push_back(r);
            end
            CMD_READ: begin
                r.out_pos_x = pos_mem[it.index][0];
                r.out_pos_y = pos_mem[it.index][1];
                r.out_pos_z = pos_mem[it.index][2];
                r.out_vel_x = vel_mem[it.index][0];
                r.out_vel_y = vel_mem[it.index][1];
                r.out_vel_z = vel_mem[it.index][2];
                r.out_type  = typ_mem[it.index];
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_item(s_data);
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_left <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction %h", m_data);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("out_pos_x", e.out_pos_x, m_data.out_pos_x);
                    check_field("out_pos_y", e.out_pos_y, m_data.out_pos_y);
                    check_field("out_pos_z", e.out_pos_z, m_data.out_pos_z);
                    check_field("out_vel_x", e.out_vel_x, m_data.out_vel_x);
                    check_field("out_vel_y", e.out_vel_y, m_data.out_vel_y);
                    check_field("out_vel_z", e.out_vel_z, m_data.out_vel_z);
                    check_field("out_type", 32'(e.out_type), 32'(m_data.out_type));
                    check_field("impulse_count", 32'(e.impulse_count),
                                32'(m_data.impulse_count));
                end
            end
            if ((hold_req && !hold_done) || hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic reg_write(logic [2:0] regno, logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regno, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (regno)
            REG_COUNT: cfg_count = value[10:0];
            REG_DIST:  cfg_dist  = value[61:0];
            REG_REST:  cfg_rest  = value[16:0];
            REG_STEP:  cfg_step  = value[30:0];
            default: ;
        endcase
    endtask

    function automatic item_t particle(int idx, logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
                                       logic [31:0] vz, logic [1:0] t);
        item_t it;
        it = '{CMD_WRITE, idx[9:0], px, py, pz, vx, vy, vz, t};
        if (!(idx inside {stored_idx})) stored_idx.push_back(idx);
        return it;
    endfunction

    function automatic item_t command(logic [1:0] c, int idx);
        item_t it;
        it = '0;
        it.cmd   = c;
        it.index = idx[9:0];
        it.pos_x = $urandom;
        it.vel_z = $urandom;
        it.ptype = 2'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic logic [31:0] near(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_round(int phase);
        int n, sel;
        logic [1:0] t;
        n = $urandom_range(2, 10);
        sel = $urandom_range(0, 3);
        reg_write(REG_COUNT, 64'((sel == 0) ? 0 : n));
        reg_write(REG_DIST, 64'((sel == 1) ? DIST_MAX : (sel == 2) ? {$urandom, $urandom} >> 2
                            : DIST_NEAR));
        sel = $urandom_range(0, 3);
        reg_write(REG_REST, 64'((sel == 0) ? 0 : (sel == 1) ? 65536 : (sel == 2) ? 131071
                            : $urandom_range(0, 65536)));
        sel = $urandom_range(0, 3);
        reg_write(REG_STEP, 64'((sel == 0) ? 0 : (sel == 1) ? 31'h7FFF_FFFF
                            : $urandom_range(0, 131072)));
        if ($urandom_range(0, 3) == 0)
            reg_write(REG_MASS, 64'($urandom_range(1, 32'h7FFF_FFFF)));
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            t = ($urandom_range(0, 2) != 0) ? TYPE_FLUID : 2'($urandom_range(1, 3));
            if (sel == 0)
                pending_items.push_back(particle(i, $urandom, $urandom, $urandom, $urandom,
                                                 $urandom, $urandom, t));
            else
                pending_items.push_back(particle(i, near(131072), near(131072), near(131072),
                                                 near(262144), near(262144), near(262144), t));
        end
        if ($urandom_range(0, 3) == 0) begin
            sel = $urandom_range(16, 1023);
            pending_items.push_back(particle(sel, $urandom, $urandom, $urandom, $urandom,
                                             $urandom, $urandom, 2'($urandom_range(0, 3))));
        end
        if ($urandom_range(0, 4) == 0) pending_items.push_back(command(CMD_NOP, $urandom));
        if (phase == 2 && !hold_req) begin
            hold_req = 1;
            pending_items.push_back(command(CMD_READ, 0));
            pending_items.push_back(command(CMD_READ, 0));
        end
        pending_items.push_back(command(CMD_RUN, $urandom));
        repeat ($urandom_range(1, 3))
            pending_items.push_back(command(CMD_READ,
                                    stored_idx[$urandom_range(0, stored_idx.size() - 1)]));
        drain();
    endtask

    initial begin
        for (int i = 0; i < NPART; i++) begin
            pos_mem[i] = '{0, 0, 0};
            vel_mem[i] = '{0, 0, 0};
            typ_mem[i] = TYPE_FLUID;
        end
        cfg_count = 0;
        cfg_dist  = 0;
        cfg_rest  = 0;
        cfg_step  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        reg_write(REG_COUNT, 64'd4);
        reg_write(REG_DIST, 64'(DIST_MAX));
        reg_write(REG_REST, 64'd65536);
        reg_write(REG_STEP, 64'd65536);
        reg_write(REG_MASS, 64'd1);
        // head-on pair, coincident pair, odd type partner, range extremes
        pending_items.push_back(particle(0, 0, 0, 0, 32'h0001_0000, 0, 0, TYPE_FLUID));
        pending_items.push_back(particle(1, 32'h0001_0000, 0, 0, 0, 0, 0, TYPE_WALL));
        pending_items.push_back(particle(2, 0, 0, 0, 32'hFFFF_0000, 0, 0, TYPE_FLUID));
        pending_items.push_back(particle(3, 0, 32'h0000_8000, 0, 0, 32'h8000_0000, 0,
                                         TYPE_ODD));
        pending_items.push_back(particle(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                         32'h8000_0000, 32'h7FFF_FFFF, 0, TYPE_ODD));
        pending_items.push_back(particle(512, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                         32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                         TYPE_GHOST));
        pending_items.push_back(command(CMD_NOP, 5));
        pending_items.push_back(command(CMD_RUN, 1023));
        for (int i = 0; i < 4; i++) pending_items.push_back(command(CMD_READ, i));
        pending_items.push_back(command(CMD_READ, 1023));
        pending_items.push_back(command(CMD_READ, 512));
        pending_items.push_back(command(CMD_RUN, 0));
        pending_items.push_back(command(CMD_READ, 0));
        drain();
        reg_write(REG_MASS, 64'h7FFF_FFFF);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 8 : (phase == 1) ? 80 : 0;
            recv_idle = (phase == 0) ? 80 : (phase == 1) ? 8 : 0;
            repeat (3) random_round(phase);
        end
        drain();
        repeat (50) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
